// ----- design/clcd_pkg.sv -----
// Shared types and constants for the character LCD command parser.
// Used by every module of the block; depends on nothing else.
package clcd_pkg;

    // Parser modes.
    typedef enum logic [2:0] {
        MODE_TEXT     = 3'd0,
        MODE_SET_CODE = 3'd1,
        MODE_LEVEL    = 3'd2,
        MODE_ADDRESS  = 3'd3,
        MODE_RECORD   = 3'd4
    } clcd_mode_t;

    // Display operations carried by a result item.
    typedef enum logic [2:0] {
        OP_WRITE_CHAR = 3'd0,
        OP_CLEAR      = 3'd1,
        OP_GLYPH_ADDR = 3'd2,
        OP_GLYPH_ROW  = 3'd3,
        OP_CONTRAST   = 3'd4,
        OP_BUS_ADDR   = 3'd5
    } clcd_op_t;

    // Configuration register indexes.
    typedef enum logic {
        CFG_SETTING_ESCAPE = 1'b0,
        CFG_COMMAND_ESCAPE = 1'b1
    } clcd_cfg_idx_t;

    // Back end sequencer states.
    typedef enum logic {
        BACK_CMD  = 1'b0,
        BACK_ROWS = 1'b1
    } clcd_back_state_t;

    localparam logic [7:0] SETTING_ESCAPE_RESET = 8'd124;
    localparam logic [7:0] COMMAND_ESCAPE_RESET = 8'd254;

    // Setting mode codes.
    localparam logic [7:0] SET_CONTRAST     = 8'd24;
    localparam logic [7:0] SET_ADDRESS      = 8'd25;
    localparam logic [7:0] SET_RECORD_FIRST = 8'd27;
    localparam logic [7:0] SET_RECORD_LAST  = 8'd34;
    localparam logic [7:0] SET_GLYPH_FIRST  = 8'd35;
    localparam logic [7:0] SET_GLYPH_LAST   = 8'd42;
    localparam logic [7:0] SET_CLEAR        = 8'd45;

    // Glyph RAM address command base and index of the final glyph row.
    localparam logic [8:0] CGRAM_CMD      = 9'h040;
    localparam logic [2:0] GLYPH_ROW_LAST = 3'd7;

    // One queued display command (also the payload of a result item).
    typedef struct packed {
        clcd_op_t   op;
        logic [3:0] col;
        logic       row;
        logic [8:0] value;
    } clcd_cmd_t;

    // Glyph row read request from the back end to the front end.
    typedef struct packed {
        logic       done;
        logic [2:0] idx;
    } clcd_glyph_req_t;

endpackage

// ----- design/clcd_front.sv -----
// Front end of the LCD command parser: mode machine, cursor tracking,
// configuration registers and the custom glyph row buffer. Uses clcd_pkg.
module clcd_front #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [7:0]                 cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 in_byte,
    output logic                       push,
    output clcd_pkg::clcd_cmd_t        push_cmd,
    input  logic                       q_full,
    input  clcd_pkg::clcd_glyph_req_t  glyph_req,
    output logic [7:0]                 glyph_row
);

    localparam logic [3:0] ColLast = 4'(COLUMNS - 1);
    localparam logic       RowLast = 1'(ROWS - 1);

    clcd_pkg::clcd_mode_t mode_reg, mode_next;
    logic [3:0] col_reg, col_next;
    logic       row_reg, row_next;
    logic [2:0] slot_reg, slot_next;
    logic [2:0] ridx_reg, ridx_next;
    logic       busy_reg, busy_next;
    logic [7:0] set_esc_reg, cmd_esc_reg;
    logic [7:0] glyph_rows_reg [8];
    logic       fire;
    logic [3:0] col_adv;
    logic       row_adv;

    assign in_ready  = !q_full && !(mode_reg == clcd_pkg::MODE_RECORD && busy_reg);
    assign fire      = in_valid && in_ready;
    assign glyph_row = glyph_rows_reg[glyph_req.idx];

    // Cursor position after one written character.
    always_comb
    begin
        if (col_reg == ColLast)
        begin
            col_adv = 4'd0;
            row_adv = (row_reg == RowLast) ? 1'b0 : row_reg + 1'b1;
        end
        else
        begin
            col_adv = col_reg + 4'd1;
            row_adv = row_reg;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        ridx_next = ridx_reg;
        push      = 1'b0;
        push_cmd  = '{op: clcd_pkg::OP_WRITE_CHAR, col: col_reg, row: row_reg,
                      value: {1'b0, in_byte}};
        if (fire)
        begin
            case (mode_reg)
                clcd_pkg::MODE_TEXT:
                begin
                    if (in_byte == set_esc_reg)
                    begin
                        mode_next = clcd_pkg::MODE_SET_CODE;
                    end
                    else if (in_byte != cmd_esc_reg)
                    begin
                        push     = 1'b1;
                        col_next = col_adv;
                        row_next = row_adv;
                    end
                end
                clcd_pkg::MODE_SET_CODE:
                begin
                    mode_next = clcd_pkg::MODE_TEXT;
                    if (in_byte == clcd_pkg::SET_CONTRAST)
                    begin
                        mode_next = clcd_pkg::MODE_LEVEL;
                    end
                    else if (in_byte == clcd_pkg::SET_ADDRESS)
                    begin
                        mode_next = clcd_pkg::MODE_ADDRESS;
                    end
                    else if (in_byte inside {[clcd_pkg::SET_RECORD_FIRST:
                                              clcd_pkg::SET_RECORD_LAST]})
                    begin
                        mode_next = clcd_pkg::MODE_RECORD;
                        slot_next = 3'(in_byte - clcd_pkg::SET_RECORD_FIRST);
                    end
                    else if (in_byte inside {[clcd_pkg::SET_GLYPH_FIRST:
                                              clcd_pkg::SET_GLYPH_LAST]})
                    begin
                        slot_next      = 3'(in_byte - clcd_pkg::SET_GLYPH_FIRST);
                        push           = 1'b1;
                        push_cmd.value = {6'd0, slot_next};
                        col_next       = col_adv;
                        row_next       = row_adv;
                    end
                    else if (in_byte == clcd_pkg::SET_CLEAR)
                    begin
                        push     = 1'b1;
                        push_cmd = '{op: clcd_pkg::OP_CLEAR, col: 4'd0, row: 1'b0,
                                     value: 9'd0};
                        col_next = 4'd0;
                        row_next = 1'b0;
                    end
                end
                clcd_pkg::MODE_LEVEL:
                begin
                    mode_next = clcd_pkg::MODE_TEXT;
                    push      = 1'b1;
                    push_cmd  = '{op: clcd_pkg::OP_CONTRAST, col: 4'd0, row: 1'b0,
                                  value: {in_byte, 1'b0}};
                end
                clcd_pkg::MODE_ADDRESS:
                begin
                    mode_next = clcd_pkg::MODE_TEXT;
                    push      = 1'b1;
                    push_cmd  = '{op: clcd_pkg::OP_BUS_ADDR, col: 4'd0, row: 1'b0,
                                  value: {1'b0, in_byte}};
                end
                clcd_pkg::MODE_RECORD:
                begin
                    if (ridx_reg != clcd_pkg::GLYPH_ROW_LAST)
                    begin
                        ridx_next = ridx_reg + 3'd1;
                    end
                    else
                    begin
                        ridx_next = 3'd0;
                        mode_next = clcd_pkg::MODE_TEXT;
                        push      = 1'b1;
                        push_cmd  = '{op: clcd_pkg::OP_GLYPH_ADDR, col: 4'd0, row: 1'b0,
                                      value: clcd_pkg::CGRAM_CMD
                                             | {3'd0, slot_reg, 3'd0}};
                    end
                end
                default:
                begin
                    mode_next = clcd_pkg::MODE_TEXT;
                end
            endcase
        end
    end

    // The row buffer stays locked from the glyph address command until the
    // back end has read the final row.
    always_comb
    begin
        busy_next = busy_reg;
        if (push && push_cmd.op == clcd_pkg::OP_GLYPH_ADDR)
        begin
            busy_next = 1'b1;
        end
        else if (glyph_req.done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= clcd_pkg::MODE_TEXT;
            col_reg     <= 4'd0;
            row_reg     <= 1'b0;
            slot_reg    <= 3'd0;
            ridx_reg    <= 3'd0;
            busy_reg    <= 1'b0;
            set_esc_reg <= clcd_pkg::SETTING_ESCAPE_RESET;
            cmd_esc_reg <= clcd_pkg::COMMAND_ESCAPE_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
            ridx_reg <= ridx_next;
            busy_reg <= busy_next;
            if (cfg_we && cfg_index == clcd_pkg::CFG_SETTING_ESCAPE)
            begin
                set_esc_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == clcd_pkg::CFG_COMMAND_ESCAPE)
            begin
                cmd_esc_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && mode_reg == clcd_pkg::MODE_RECORD)
        begin
            glyph_rows_reg[ridx_reg] <= in_byte;
        end
    end

endmodule

// ----- design/clcd_queue.sv -----
// Two-entry command queue between the front and back ends of the
// LCD command parser. Uses clcd_pkg for the command type.
module clcd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  clcd_pkg::clcd_cmd_t  push_cmd,
    output logic                 full,
    input  logic                 pop,
    output clcd_pkg::clcd_cmd_t  pop_cmd,
    output logic                 empty
);

    clcd_pkg::clcd_cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (push ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (pop ? 1'b1 : 1'b0);
        count_next  = count_reg + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- design/clcd_back.sv -----
// Back end of the LCD command parser: takes queued commands and drives the
// registered result stream, expanding a glyph into its eight rows. Uses clcd_pkg.
module clcd_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  clcd_pkg::clcd_cmd_t        q_cmd,
    output logic                       q_pop,
    output clcd_pkg::clcd_glyph_req_t  glyph_req,
    input  logic [7:0]                 glyph_row,
    output logic                       out_valid,
    input  logic                       out_ready,
    output clcd_pkg::clcd_cmd_t        out_cmd,
    output logic                       out_last
);

    clcd_pkg::clcd_back_state_t state_reg, state_next;
    logic [2:0]          idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    clcd_pkg::clcd_cmd_t out_cmd_reg, out_cmd_next;
    logic                out_last_reg, out_last_next;
    logic                load_en;

    assign load_en   = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_cmd   = out_cmd_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_cmd_next   = out_cmd_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        glyph_req.idx  = idx_reg;
        glyph_req.done = 1'b0;
        if (load_en)
        begin
            case (state_reg)
                clcd_pkg::BACK_ROWS:
                begin
                    out_valid_next = 1'b1;
                    out_cmd_next   = '{op: clcd_pkg::OP_GLYPH_ROW, col: 4'd0, row: 1'b0,
                                       value: {1'b0, glyph_row}};
                    out_last_next  = (idx_reg == clcd_pkg::GLYPH_ROW_LAST);
                    if (idx_reg == clcd_pkg::GLYPH_ROW_LAST)
                    begin
                        state_next     = clcd_pkg::BACK_CMD;
                        idx_next       = 3'd0;
                        glyph_req.done = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
                clcd_pkg::BACK_CMD:
                begin
                    out_valid_next = !q_empty;
                    if (!q_empty)
                    begin
                        q_pop         = 1'b1;
                        out_cmd_next  = q_cmd;
                        out_last_next = (q_cmd.op != clcd_pkg::OP_GLYPH_ADDR);
                        if (q_cmd.op == clcd_pkg::OP_GLYPH_ADDR)
                        begin
                            state_next = clcd_pkg::BACK_ROWS;
                            idx_next   = 3'd0;
                        end
                    end
                end
                default:
                begin
                    state_next = clcd_pkg::BACK_CMD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clcd_pkg::BACK_CMD;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_cmd_reg  <= out_cmd_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ----- design/char_lcd_command_parser.sv -----
// Top level of the character LCD command parser: front end, command queue
// and back end. Depends on clcd_pkg, clcd_front, clcd_queue and clcd_back.
//
//   Channel   Direction  Handshake                      Payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  rx_byte
//   m_axis    out        m_axis_tvalid / m_axis_tready  op, cursor_col, cursor_row, value;
//                                                       last on m_axis_tlast
//   cfg       in         cfg_we (no wait)               cfg_index selects, cfg_data
//
// A received item is taken while the queue has room, apart from the hold-off
// below; a byte that causes one result passes through the queue and the result
// register to m_axis. A finished glyph gives nine result items, one per cycle
// from the back end's row sequencer while m_axis is ready.
// While those rows are still being sent, the first row byte of a new recording
// is held off, because the row buffer is still being read.
// Reset (rst_n, asynchronous, active low) returns the mode to normal, the
// cursor to the top left, and the escape registers to 124 and 254.
// A stall on m_axis backs up into the two-entry queue and then onto s_axis.
module char_lcd_command_parser #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // Received bytes.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Display commands.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [2:0] op, [6:3] cursor_col, [7] cursor_row,
                                        // [16:8] value, [23:17] zero
    output logic        m_axis_tlast
);

    // Front to queue.
    logic                      push;
    clcd_pkg::clcd_cmd_t       push_cmd;
    logic                      q_full;
    // Queue to back.
    logic                      q_pop;
    clcd_pkg::clcd_cmd_t       q_cmd;
    logic                      q_empty;
    // Glyph row buffer read by the back end.
    clcd_pkg::clcd_glyph_req_t glyph_req;
    logic [7:0]                glyph_row;
    // Result register contents.
    clcd_pkg::clcd_cmd_t       out_cmd;

    // The front end decodes each byte against the mode machine and queues
    // at most one command per byte. A glyph is queued as a single address
    // command; the back end expands it by reading the row buffer here.
    clcd_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .push      (push),
        .push_cmd  (push_cmd),
        .q_full    (q_full),
        .glyph_req (glyph_req),
        .glyph_row (glyph_row)
    );

    // Short queue so the front end keeps taking bytes while the output stalls.
    clcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_cmd),
        .empty    (q_empty)
    );

    // The back end owns the output register.
    clcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .glyph_req (glyph_req),
        .glyph_row (glyph_row),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_cmd   (out_cmd),
        .out_last  (m_axis_tlast)
    );

    // Pack the result fields, lowest field first, padded to three bytes.
    assign m_axis_tdata = {7'd0, out_cmd.value, out_cmd.row, out_cmd.col, out_cmd.op};

endmodule

// ----- design/clcd_checker.sv -----
// Port-level checker for the character LCD command parser, bound to the top
// level. Depends on the top level's result ports and on clcd_pkg.
module clcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result item stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item withdrawn while stalled");

    // Only the six defined operations appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= clcd_pkg::OP_BUS_ADDR)
        else $error("undefined operation on output");

    // Cursor fields are zero for everything except a written character.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != clcd_pkg::OP_WRITE_CHAR
        |-> m_axis_tdata[7:3] == 5'd0)
        else $error("cursor fields set on a non-character item");

    // Only a glyph transfer has items that are not the last of their byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast
        |-> m_axis_tdata[2:0] == clcd_pkg::OP_GLYPH_ADDR
            || m_axis_tdata[2:0] == clcd_pkg::OP_GLYPH_ROW)
        else $error("unexpected non-final item");

    // The glyph address command is followed at once by its first row.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tdata[2:0] == clcd_pkg::OP_GLYPH_ADDR
        |=> m_axis_tvalid && m_axis_tdata[2:0] == clcd_pkg::OP_GLYPH_ROW)
        else $error("glyph rows do not follow the address command");

endmodule

bind char_lcd_command_parser clcd_checker u_clcd_checker (.*);

// ----- test/char_lcd_command_parser_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_command_parser: sends received bytes on s_axis,
// predicts every display command and checks each m_axis item against the prediction.
// Depends on clcd_pkg and the char_lcd_command_parser design.
module char_lcd_command_parser_tb;

    localparam int COLUMNS       = 16;
    localparam int ROWS          = 2;
    // The slowest correct run is roughly 250 items, each with a long sender gap and up to
    // nine results behind long receiver stalls, plus the long hold-off, so this limit
    // leaves plenty of margin.
    localparam int CYCLE_LIMIT   = 400000;
    // A byte that causes a result passes through the queue and the result register to m_axis.
    // Bytes that give no result may still be in flight when the queue runs empty, so wait this out too.
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;
    localparam int LONG_HOLD     = 300;

    // One predicted display command, as carried by an m_axis item.
    typedef struct {
        clcd_pkg::clcd_op_t op;
        logic [3:0]         col;
        logic               row;
        logic [8:0]         value;
        logic               last;
    } lcd_cmd_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic        cfg_index     = 1'b0;
    logic [7:0]  cfg_data      = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [2:0] op, [6:3] cursor_col, [7] cursor_row,
                                         // [16:8] value, [23:17] zero
    logic        m_axis_tlast;

    // Commands the display should receive, oldest first.
    lcd_cmd_t expected_cmds[$];

    // Our own copy of the parser state and of the two escape registers.
    clcd_pkg::clcd_mode_t p_mode;
    logic [3:0]           p_col;
    logic                 p_row;
    logic [2:0]           p_slot;
    logic [2:0]           p_row_idx;
    logic [7:0]           p_glyph [8];
    logic [7:0]           p_set_esc;
    logic [7:0]           p_cmd_esc;

    int fail_count      = 0;
    int items_sent      = 0;
    int cycle_count     = 0;
    // Cycles the receiver still has to hold off; set by the back-pressure test.
    int out_hold_cycles = 0;
    // When set, neither side idles.
    bit steady_flow     = 1'b0;

    char_lcd_command_parser #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #4 clk = ~clk;

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Idle length for either side: mostly none, often a few cycles, now and then long.
    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    task automatic push_cmd(input clcd_pkg::clcd_op_t op, input logic [3:0] col,
                            input logic row, input logic [8:0] value, input logic last);
        lcd_cmd_t c;
        c.op    = op;
        c.col   = col;
        c.row   = row;
        c.value = value;
        c.last  = last;
        expected_cmds.push_back(c);
    endtask

    // A character goes out at the tracked cursor, which then moves one column on,
    // wrapping to the next row at the right edge and back to the top after the last row.
    task automatic place_char(input logic [7:0] ch);
        push_cmd(clcd_pkg::OP_WRITE_CHAR, p_col, p_row, {1'b0, ch}, 1'b1);
        if (int'(p_col) + 1 >= COLUMNS)
        begin
            p_col = 4'd0;
            if (int'(p_row) + 1 >= ROWS)
                p_row = 1'b0;
            else
                p_row = p_row + 1'b1;
        end
        else
        begin
            p_col = p_col + 4'd1;
        end
    endtask

    // Advances the predicted parser by one accepted byte and queues what it should emit.
    task automatic decode_byte(input logic [7:0] b);
        case (p_mode)
            clcd_pkg::MODE_TEXT:
            begin
                // The setting escape takes precedence when both escapes are equal.
                if (b == p_set_esc)
                    p_mode = clcd_pkg::MODE_SET_CODE;
                else if (b != p_cmd_esc)
                    place_char(b);
            end
            clcd_pkg::MODE_SET_CODE:
            begin
                // Codes with no action fall through and just return to normal mode.
                p_mode = clcd_pkg::MODE_TEXT;
                if (b == clcd_pkg::SET_CONTRAST)
                begin
                    p_mode = clcd_pkg::MODE_LEVEL;
                end
                else if (b == clcd_pkg::SET_ADDRESS)
                begin
                    p_mode = clcd_pkg::MODE_ADDRESS;
                end
                else if (b >= clcd_pkg::SET_RECORD_FIRST && b <= clcd_pkg::SET_RECORD_LAST)
                begin
                    p_mode = clcd_pkg::MODE_RECORD;
                    p_slot = 3'(b - clcd_pkg::SET_RECORD_FIRST);
                end
                else if (b >= clcd_pkg::SET_GLYPH_FIRST && b <= clcd_pkg::SET_GLYPH_LAST)
                begin
                    p_slot = 3'(b - clcd_pkg::SET_GLYPH_FIRST);
                    place_char({5'd0, p_slot});
                end
                else if (b == clcd_pkg::SET_CLEAR)
                begin
                    p_col = 4'd0;
                    p_row = 1'b0;
                    push_cmd(clcd_pkg::OP_CLEAR, 4'd0, 1'b0, 9'd0, 1'b1);
                end
            end
            clcd_pkg::MODE_LEVEL:
            begin
                p_mode = clcd_pkg::MODE_TEXT;
                push_cmd(clcd_pkg::OP_CONTRAST, 4'd0, 1'b0, {b, 1'b0}, 1'b1);
            end
            clcd_pkg::MODE_ADDRESS:
            begin
                p_mode = clcd_pkg::MODE_TEXT;
                push_cmd(clcd_pkg::OP_BUS_ADDR, 4'd0, 1'b0, {1'b0, b}, 1'b1);
            end
            clcd_pkg::MODE_RECORD:
            begin
                p_glyph[p_row_idx] = b;
                if (p_row_idx != clcd_pkg::GLYPH_ROW_LAST)
                begin
                    p_row_idx = p_row_idx + 3'd1;
                end
                else
                begin
                    // Eighth row: address command, then the rows with last on the final one.
                    p_row_idx = 3'd0;
                    p_mode    = clcd_pkg::MODE_TEXT;
                    push_cmd(clcd_pkg::OP_GLYPH_ADDR, 4'd0, 1'b0,
                             clcd_pkg::CGRAM_CMD | {3'd0, p_slot, 3'd0}, 1'b0);
                    for (int i = 0; i < 8; i++)
                        push_cmd(clcd_pkg::OP_GLYPH_ROW, 4'd0, 1'b0, {1'b0, p_glyph[i]},
                                 i == 7);
                end
            end
            default:
            begin
                p_mode = clcd_pkg::MODE_TEXT;
            end
        endcase
    endtask

    // Offers one byte, after a random gap, and predicts its effect once it is accepted.
    // Called at a rising edge; tvalid stays high between items that follow back to back.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        decode_byte(b);
        items_sent++;
    endtask

    // Stops offering items until every expected command has arrived and, if asked,
    // lets the pipeline settle so that the block is idle.
    task automatic wait_for_results(input bit settle);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_cmds.size() != 0)
            @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes take effect at the edge where cfg_we is high; only call when idle.
    task automatic write_escape(input clcd_pkg::clcd_cfg_idx_t idx, input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == clcd_pkg::CFG_SETTING_ESCAPE)
            p_set_esc = v;
        else
            p_cmd_esc = v;
        @(posedge clk);
    endtask

    task automatic send_setting(input logic [7:0] code);
        send_byte(p_set_esc);
        send_byte(code);
    endtask

    // Field extremes and every setting action except recording under the reset escapes.
    task automatic test_directed_commands();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(p_cmd_esc);                      // swallowed
        send_setting(clcd_pkg::SET_CONTRAST);
        send_byte(8'hFF);                          // contrast 510
        send_setting(clcd_pkg::SET_ADDRESS);
        send_byte(8'h80);
        send_setting(clcd_pkg::SET_GLYPH_LAST);    // shows glyph 7 at the cursor
        send_setting(clcd_pkg::SET_CLEAR);         // homes the cursor
        send_setting(8'd26);                       // code without action
        send_byte(8'h41);
    endtask

    // A full recording of slot 0: eight rows, then nine commands out.
    task automatic test_glyph_record();
        send_setting(clcd_pkg::SET_RECORD_FIRST);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h1F);
        send_byte(8'h10);
    endtask

    // Mostly well-formed command sequences with random content, some plain noise.
    task automatic send_random_sequence();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (r < 42)
        begin
            send_byte(p_cmd_esc);
        end
        else if (r < 52)
        begin
            send_setting(clcd_pkg::SET_CONTRAST);
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (r < 62)
        begin
            send_setting(clcd_pkg::SET_ADDRESS);
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (r < 65)
        begin
            send_setting(clcd_pkg::SET_CLEAR);
        end
        else if (r < 75)
        begin
            send_setting(8'($urandom_range(clcd_pkg::SET_GLYPH_FIRST,
                                           clcd_pkg::SET_GLYPH_LAST)));
        end
        else if (r < 92)
        begin
            send_setting(8'($urandom_range(clcd_pkg::SET_RECORD_FIRST,
                                           clcd_pkg::SET_RECORD_LAST)));
            repeat (8) send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            // Any setting code at all, most of them without action.
            send_setting(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            // Stretches without idling come and go.
            if ($urandom_range(0, 9) == 0)
                steady_flow = !steady_flow;
            if ($urandom_range(0, 29) == 0)
                wait_for_results(1'b0);
            send_random_sequence();
        end
        steady_flow = 1'b0;
    endtask

    // The receiver holds off for a long stretch while printable characters keep coming,
    // so the queue fills and s_axis stalls. 34 characters also wrap both rows.
    task automatic test_backpressure_fill();
        steady_flow     = 1'b1;
        out_hold_cycles = LONG_HOLD;
        repeat (34) send_byte(8'($urandom_range(32, 122)));
        steady_flow     = 1'b0;
    endtask

    // With both escapes equal, the shared value must enter setting mode.
    task automatic test_equal_escapes();
        wait_for_results(1'b1);
        write_escape(clcd_pkg::CFG_SETTING_ESCAPE, 8'hA5);
        write_escape(clcd_pkg::CFG_COMMAND_ESCAPE, 8'hA5);
        while (p_mode != clcd_pkg::MODE_TEXT)
            send_byte(8'h41);
        send_setting(clcd_pkg::SET_CLEAR);
        send_setting(clcd_pkg::SET_CONTRAST);
        send_byte(8'h7F);
        send_byte(8'hFE);                          // an ordinary character now
    endtask

    // Receiver: random stalls, the long hold-off on request, steady during quiet stretches.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                out_hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Each accepted result is compared with the oldest prediction.
    always @(posedge clk)
    begin
        lcd_cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_cmds.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected item: op=%0d col=%0d row=%0d value=%0d last=%0d",
                             m_axis_tdata[2:0], m_axis_tdata[6:3], m_axis_tdata[7],
                             m_axis_tdata[16:8], m_axis_tlast);
            end
            else
            begin
                want = expected_cmds.pop_front();
                if (m_axis_tdata[2:0] !== want.op || m_axis_tdata[6:3] !== want.col ||
                    m_axis_tdata[7] !== want.row || m_axis_tdata[16:8] !== want.value ||
                    m_axis_tdata[23:17] !== 7'd0 || m_axis_tlast !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("mismatch: expected op=%0d col=%0d row=%0d value=%0d last=%0d",
                                 want.op, want.col, want.row, want.value, want.last);
                        $display("          got op=%0d col=%0d row=%0d value=%0d last=%0d pad=%0h",
                                 m_axis_tdata[2:0], m_axis_tdata[6:3], m_axis_tdata[7],
                                 m_axis_tdata[16:8], m_axis_tlast, m_axis_tdata[23:17]);
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("char_lcd_command_parser_tb: FAIL");
        $finish;
    end

    initial
    begin
        p_mode    = clcd_pkg::MODE_TEXT;
        p_col     = 4'd0;
        p_row     = 1'b0;
        p_slot    = 3'd0;
        p_row_idx = 3'd0;
        p_set_esc = clcd_pkg::SETTING_ESCAPE_RESET;
        p_cmd_esc = clcd_pkg::COMMAND_ESCAPE_RESET;
        wait (rst_n);
        @(posedge clk);

        // Reset escapes.
        test_directed_commands();
        test_glyph_record();
        test_random_traffic(45);
        test_backpressure_fill();

        // Escapes at opposite extremes.
        wait_for_results(1'b1);
        write_escape(clcd_pkg::CFG_SETTING_ESCAPE, 8'h00);
        write_escape(clcd_pkg::CFG_COMMAND_ESCAPE, 8'hFF);
        test_random_traffic(40);

        test_equal_escapes();
        test_random_traffic(30);

        wait_for_results(1'b1);
        write_escape(clcd_pkg::CFG_SETTING_ESCAPE, 8'hFF);
        write_escape(clcd_pkg::CFG_COMMAND_ESCAPE, 8'h00);
        test_random_traffic(40);

        wait_for_results(1'b1);
        if (expected_cmds.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("char_lcd_command_parser_tb: PASS");
        else
            $display("char_lcd_command_parser_tb: FAIL");
        $finish;
    end

endmodule
